### hw/rtl/tcw_pkg.sv
// Package: shared constants, types and control structs of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Internal widths derived from the geometry
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    // Fixed widths of the item fields
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = CHAR_W + COLOR_W;
    localparam int READ_ROW_W  = 5;
    localparam int READ_COL_W  = 7;
    localparam int OUT_ROW_W   = 5;
    localparam int OUT_COL_W   = 7;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    // Item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROW
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;           // input item taken this cycle
        logic clear_all;        // power-up sweep over the whole store
        logic clear_row;        // blank the row that just left the top
        logic load_result;      // capture the result item
        logic result_scrolled;  // result reports a scroll
        logic result_read;      // result carries the read cell
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;          // offered item is a read
        logic put_scrolls;      // offered put item scrolls the screen
        logic sweep_last;       // sweep is at its final cell
    } t_dp_status;

endpackage

### hw/rtl/tcw_if.sv
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps

interface tcw_item_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [tcw_pkg::CHAR_W-1:0]      char_code;
    logic [tcw_pkg::READ_ROW_W-1:0]  read_row;
    logic [tcw_pkg::READ_COL_W-1:0]  read_column;

    modport source (output valid, kind, char_code, read_row, read_column, input ready);
    modport sink   (input valid, kind, char_code, read_row, read_column, output ready);
endinterface

interface tcw_result_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_row;
    logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column;
    logic                            scrolled;
    logic [tcw_pkg::CHAR_W-1:0]      cell_char;
    logic [tcw_pkg::COLOR_W-1:0]     cell_color;

    modport source (output valid, cursor_row, cursor_column, scrolled, cell_char, cell_color,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_column, scrolled, cell_char, cell_color,
                    output ready);
endinterface

interface tcw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::COLOR_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/text_console_writer.sv
// Top level: text console writer, joining controller, datapath and channels.
`timescale 1ns / 1ps

// Character-cell console store of ROWS by COLUMNS cells (25 x 80), each cell a
// character byte and an attribute byte. After reset the block sweeps all
// ROWS*COLUMNS cells (2000), blanking the store to spaces with attribute 0x07,
// and takes no item meanwhile; color writes are taken at any time. Rows sit
// in the store as a ring behind a row base, so a scroll moves the base rather
// than the rows. A put item that does not scroll completes in the cycle it is
// taken; a read item passes through a read state, as the store has a registered
// read port; a put item that scrolls passes through a row-blank state, as the
// single write port of the store blanks the new bottom row one cell a cycle. A
// finished result waits in an output register, and a new item is taken in
// the same cycle that the waiting result is taken.
module text_console_writer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_item_if.sink      i_item,
    tcw_result_if.source  o_result,
    tcw_cfg_if.sink       i_cfg
);

    tcw_pkg::t_dp_cmd    cmd;
    tcw_pkg::t_dp_status status;
    logic                in_ready;
    logic                out_valid;
    logic                cfg_ready;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_item.kind),
        .i_char_code     (i_item.char_code),
        .i_read_row      (i_item.read_row),
        .i_read_column   (i_item.read_column),
        .i_cfg_valid     (i_cfg.valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (i_cfg.data),
        .o_cursor_row    (o_result.cursor_row),
        .o_cursor_column (o_result.cursor_column),
        .o_scrolled      (o_result.scrolled),
        .o_cell_char     (o_result.cell_char),
        .o_cell_color    (o_result.cell_color)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;
    assign i_cfg.ready    = cfg_ready;

endmodule

### hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tcw_datapath.sv
// Datapath: cursor, row base, color register, cell store and result register.
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_dp_cmd                 i_cmd,
    output tcw_pkg::t_dp_status              o_status,
    input  logic                             i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::READ_ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::READ_COL_W-1:0]   i_read_column,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]      i_cfg_data,
    output logic [tcw_pkg::OUT_ROW_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::OUT_COL_W-1:0]    o_cursor_column,
    output logic                             o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]      o_cell_color
);

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;

    logic [ROW_W-1:0]             r_row, n_row;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_base, n_base;
    logic [tcw_pkg::COLOR_W-1:0]  r_color;
    logic [ADDR_W-1:0]            r_sweep, n_sweep;
    logic [ADDR_W-1:0]            r_clear_base;
    logic                         r_read_ok;

    logic [tcw_pkg::OUT_ROW_W-1:0] r_out_row;
    logic [tcw_pkg::OUT_COL_W-1:0] r_out_col;
    logic                          r_out_scrolled;
    logic [tcw_pkg::CHAR_W-1:0]    r_out_char;
    logic [tcw_pkg::COLOR_W-1:0]   r_out_color;

    logic [ROW_W:0]               cur_sum, rd_sum;
    logic [ROW_W:0]               cur_phys, rd_phys;
    logic [ADDR_W-1:0]            cur_addr, rd_addr;
    logic                         read_in_range;
    logic                         is_newline, end_col, last_row, wrap, put_scrolls;
    logic                         do_put;
    logic                         sweeping, sweep_last;
    logic                         ram_we, ram_re;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_wdata, ram_rdata;

    // Map the cursor row through the circular row base
    always_comb begin
        cur_sum  = {1'b0, r_row} + {1'b0, r_base};
        cur_phys = (cur_sum >= (ROW_W+1)'(tcw_pkg::ROWS))
                 ? cur_sum - (ROW_W+1)'(tcw_pkg::ROWS) : cur_sum;
        cur_addr = ADDR_W'(cur_phys * tcw_pkg::COLUMNS) + ADDR_W'(r_col);
    end

    // Map the requested read cell through the circular row base
    always_comb begin
        read_in_range = (32'(i_read_row) < tcw_pkg::ROWS)
                     && (32'(i_read_column) < tcw_pkg::COLUMNS);
        rd_sum  = {1'b0, ROW_W'(i_read_row)} + {1'b0, r_base};
        rd_phys = (rd_sum >= (ROW_W+1)'(tcw_pkg::ROWS))
                ? rd_sum - (ROW_W+1)'(tcw_pkg::ROWS) : rd_sum;
        rd_addr = ADDR_W'(rd_phys * tcw_pkg::COLUMNS) + ADDR_W'(COL_W'(i_read_column));
    end

    // Classify the offered item
    always_comb begin
        is_newline  = (i_char_code == tcw_pkg::NEWLINE_CODE);
        end_col     = (r_col == COL_W'(tcw_pkg::COLUMNS - 1));
        last_row    = (r_row == ROW_W'(tcw_pkg::ROWS - 1));
        wrap        = is_newline || end_col;
        put_scrolls = (i_kind == tcw_pkg::KIND_PUT) && wrap && last_row;
        do_put      = i_cmd.accept && (i_kind == tcw_pkg::KIND_PUT);
    end

    // Advance the cursor and the row base on a put item
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_base = r_base;
        if (do_put) begin
            if (wrap) begin
                n_col = '0;
                if (last_row) begin
                    n_base = (r_base == ROW_W'(tcw_pkg::ROWS - 1)) ? '0 : r_base + 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // Step the sweep counter; wrap to zero after the final cell
    always_comb begin
        sweeping   = i_cmd.clear_all || i_cmd.clear_row;
        sweep_last = i_cmd.clear_all ? (r_sweep == ADDR_W'(tcw_pkg::CELLS - 1))
                                     : (r_sweep == ADDR_W'(tcw_pkg::COLUMNS - 1));
        n_sweep    = r_sweep;
        if (sweeping) begin
            n_sweep = sweep_last ? '0 : r_sweep + 1'b1;
        end
    end

    // Select the store write: power-up blank, row blank or character
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {r_color, i_char_code};
        if (i_cmd.clear_all) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
        end else if (i_cmd.clear_row) begin
            ram_we    = 1'b1;
            ram_waddr = r_clear_base + r_sweep;
            ram_wdata = {r_color, tcw_pkg::BLANK_CODE};
        end else if (do_put && !is_newline) begin
            ram_we    = 1'b1;
        end
        ram_re = i_cmd.accept && (i_kind == tcw_pkg::KIND_READ) && read_in_range;
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_base  <= '0;
            r_sweep <= '0;
            r_color <= tcw_pkg::RESET_COLOR;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_base  <= n_base;
            r_sweep <= n_sweep;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
        end
    end

    // Hold the row to blank and the read range check
    always_ff @(posedge i_clk) begin
        if (do_put && put_scrolls) begin
            r_clear_base <= ADDR_W'(r_base * tcw_pkg::COLUMNS);
        end
        if (i_cmd.accept) begin
            r_read_ok <= (i_kind == tcw_pkg::KIND_READ) && read_in_range;
        end
    end

    // Capture the result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_row      <= tcw_pkg::OUT_ROW_W'(n_row);
            r_out_col      <= tcw_pkg::OUT_COL_W'(n_col);
            r_out_scrolled <= i_cmd.result_scrolled;
            if (i_cmd.result_read && r_read_ok) begin
                r_out_char  <= ram_rdata[tcw_pkg::CHAR_W-1:0];
                r_out_color <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end else begin
                r_out_char  <= '0;
                r_out_color <= '0;
            end
        end
    end

    assign o_status.is_read     = (i_kind == tcw_pkg::KIND_READ);
    assign o_status.put_scrolls = put_scrolls;
    assign o_status.sweep_last  = sweep_last;

    assign o_cfg_ready     = 1'b1;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_column = r_out_col;
    assign o_scrolled      = r_out_scrolled;
    assign o_cell_char     = r_out_char;
    assign o_cell_color    = r_out_color;

endmodule

### hw/rtl/tcw_ctrl.sv
// Controller: state machine that sequences clearing, reads, puts and scrolls.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  tcw_pkg::t_dp_status  i_status,
    output tcw_pkg::t_dp_cmd     o_cmd
);

    tcw_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;
    logic            accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = (r_state == tcw_pkg::ST_IDLE) && out_free && i_in_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_status.is_read) begin
                        n_state = tcw_pkg::ST_READ;
                    end else if (i_status.put_scrolls) begin
                        n_state = tcw_pkg::ST_ROW;
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_ROW: begin
                if (i_status.sweep_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_cmd.clear_all = 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                o_in_ready   = out_free;
                o_cmd.accept = accept;
                if (accept && !i_status.is_read && !i_status.put_scrolls) begin
                    o_cmd.load_result = 1'b1;
                end
            end
            tcw_pkg::ST_READ: begin
                o_cmd.load_result = 1'b1;
                o_cmd.result_read = 1'b1;
            end
            tcw_pkg::ST_ROW: begin
                o_cmd.clear_row = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.load_result     = 1'b1;
                    o_cmd.result_scrolled = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Set on a new result, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A read item yields its result in the following cycle
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.is_read) |=> o_cmd.load_result)
        else $error("read result not produced");

    // A put item that does not scroll completes at once
    a_put_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_status.is_read && !i_status.put_scrolls) |-> o_cmd.load_result)
        else $error("put result not produced");

    // The end of a row blank presents a scrolled result
    a_scroll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_ROW && i_status.sweep_last) |=> r_out_valid)
        else $error("scroll result missing");
`endif

endmodule
